/* hw/rtl/rrss_pkg.sv */
package rrss_pkg;

	localparam int OFF_W = 64;
	localparam int BS_W  = 33;
	localparam int SC_W  = 9;
	localparam int SRV_W = 8;
	localparam int ST_W  = 2;

	localparam logic [SC_W-1:0] MAX_SERVERS = 9'd256;
	localparam int              MAX_CHUNKS  = 64;

	localparam logic [BS_W-1:0] BS_RESET = 33'd4194304;
	localparam logic [SC_W-1:0] SC_RESET = 9'd1;

	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [1:0] REG_SERVER_COUNT = 2'd1;
	localparam logic [1:0] REG_START_INDEX  = 2'd2;

	localparam logic [ST_W-1:0] STAT_OK     = 2'd0;
	localparam logic [ST_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] STAT_REJECT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLK_START,
		ST_BLK_WAIT,
		ST_CHECK,
		ST_RND_START,
		ST_RND_WAIT,
		ST_SI_START,
		ST_SI_WAIT,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIV_BLK,
		DIV_RND,
		DIV_SI
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     emit_empty;
		logic     emit_reject;
		logic     div_start;
		div_sel_t div_sel;
		logic     cap_blk;
		logic     cap_rnd;
		logic     cap_si;
		logic     mul_start;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic reject;
		logic div_busy;
		logic mul_busy;
		logic last;
		logic wrap;
		logic full;
	} stat_t;

endpackage

/* hw/rtl/round_robin_stripe_splitter.sv */
// Round robin stripe splitter.
// Slave stream carries one request per beat; master stream returns one beat
// per stripe chunk, tlast on the final beat of the request.
// Config port (cfg_we/cfg_index/cfg_data) writes block size, server count
// and first server; write only while no request is in flight.
// A zero-length request answers in the cycle after its beat with
// tuser = empty. Otherwise the first chunk costs three divisions
// (offset / block size, block / server count, first server / server count),
// a length check and a shift-add multiply before the first beat is valid.
// Each further chunk is presented in the cycle after the previous beat is
// taken. A too-long request answers after the block division and the length
// check with tuser = reject.
// Divisions run one bit a cycle in a single shared divider.
// When the offset wraps past 2^64 mid-request the block and round divisions
// and the multiply are redone before the next chunk; a request
// stops after 64 chunk beats.
// One request is handled at a time: s_tready is high only while idle.
// A stalled master holds the beat; no state advances until it is taken.
// Reset returns to idle and restores the register defaults.
module round_robin_stripe_splitter
	import rrss_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [32:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [127:0]  s_tdata,  // request_offset, request_length
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [175:0]  m_tdata,  // server_index, chunk_length, local_offset, block_number
	output logic [1:0]    m_tuser,  // status
	output logic          m_tlast
);

	cmd_t  cmd;
	stat_t stat;

	rrss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* hw/rtl/rrss_div.sv */
module rrss_div
	import rrss_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OFF_W-1:0] dividend,
	input  logic [BS_W-1:0]  divisor,
	output logic            busy,
	output logic [OFF_W-1:0] quot,
	output logic [BS_W-1:0]  rem
);

	localparam int CNT_W = $clog2(OFF_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [OFF_W-1:0] dvd_q;
	logic [BS_W-1:0]  rem_q;
	logic [BS_W-1:0]  dsr_q;
	logic [BS_W:0]    trial;
	logic             ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, dvd_q[OFF_W-1]};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(OFF_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[OFF_W-2:0], ge};
			rem_q <= ge ? BS_W'(trial - {1'b0, dsr_q}) : trial[BS_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/rrss_dp.sv */
module rrss_dp
	import rrss_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [BS_W-1:0] cfg_data,
	input  logic [127:0]  s_tdata,
	input  cmd_t          cmd,
	output stat_t         stat,
	output logic [175:0]  m_tdata,
	output logic [ST_W-1:0] m_tuser,
	output logic          m_tlast
);

	localparam int MUL_CNT_W = $clog2(BS_W + 1);
	localparam int LIM_W     = BS_W + 6;
	localparam int NCH_W     = $clog2(MAX_CHUNKS + 1);

	logic [BS_W-1:0]  cfg_bs_q;
	logic [SC_W-1:0]  cfg_sc_q;
	logic [SRV_W-1:0] cfg_si_q;

	logic [BS_W-1:0] bs;
	logic [SC_W-1:0] sc;

	logic [OFF_W-1:0] rem_len_q;
	logic [OFF_W-1:0] cur_off_q;
	logic [OFF_W-1:0] blk_q;
	logic [BS_W-1:0]  disp_q;
	logic [SC_W-1:0]  mod_q;
	logic [SRV_W-1:0] si_q;
	logic [NCH_W-1:0] nchunk_q;

	logic [OFF_W-1:0]     acc_q;
	logic [OFF_W-1:0]     mcand_q;
	logic [BS_W-1:0]      mplier_q;
	logic [MUL_CNT_W-1:0] mcnt_q;

	logic [SRV_W-1:0] srv_q;
	logic [BS_W-1:0]  clen_q;
	logic [OFF_W-1:0] loc_q;
	logic [OFF_W-1:0] oblk_q;
	logic [ST_W-1:0]  status_q;
	logic             last_q;
	logic             wrap_q;

	logic [OFF_W-1:0] div_dvd;
	logic [BS_W-1:0]  div_dsr;
	logic             div_busy;
	logic [OFF_W-1:0] div_quot;
	logic [BS_W-1:0]  div_rem;

	logic [BS_W-1:0]  room;
	logic [BS_W-1:0]  clen;
	logic [OFF_W-1:0] new_rem;
	logic [OFF_W:0]   new_off;
	logic [SC_W-1:0]  srv_sum;
	logic [SC_W-1:0]  srv;
	logic [SC_W-1:0]  mod_inc;
	logic [OFF_W-1:0] first_len;
	logic [OFF_W-1:0] rest;
	logic [LIM_W-1:0] lim;
	logic [OFF_W-1:0] in_off;
	logic [OFF_W-1:0] in_len;

	assign in_off = s_tdata[63:0];
	assign in_len = s_tdata[127:64];

	always_comb begin
		bs = (cfg_bs_q == '0) ? BS_W'(1) : cfg_bs_q;
		if (cfg_sc_q == '0) begin
			sc = SC_W'(1);
		end else if (cfg_sc_q > MAX_SERVERS) begin
			sc = MAX_SERVERS;
		end else begin
			sc = cfg_sc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bs_q <= BS_RESET;
			cfg_sc_q <= SC_RESET;
			cfg_si_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SIZE:   cfg_bs_q <= cfg_data;
				REG_SERVER_COUNT: cfg_sc_q <= cfg_data[SC_W-1:0];
				REG_START_INDEX:  cfg_si_q <= cfg_data[SRV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_BLK: begin
				div_dvd = cur_off_q;
				div_dsr = bs;
			end
			DIV_RND: begin
				div_dvd = blk_q;
				div_dsr = BS_W'(sc);
			end
			DIV_SI: begin
				div_dvd = OFF_W'(cfg_si_q);
				div_dsr = BS_W'(sc);
			end
			default: begin
				div_dvd = cur_off_q;
				div_dsr = bs;
			end
		endcase
	end

	rrss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		room      = bs - disp_q;
		clen      = (rem_len_q < OFF_W'(room)) ? rem_len_q[BS_W-1:0] : room;
		new_rem   = rem_len_q - OFF_W'(clen);
		new_off   = {1'b0, cur_off_q} + (OFF_W+1)'(clen);
		srv_sum   = SC_W'(si_q) + mod_q;
		srv       = (srv_sum >= sc) ? srv_sum - sc : srv_sum;
		mod_inc   = mod_q + 1'b1;
		first_len = (rem_len_q < OFF_W'(room)) ? rem_len_q : OFF_W'(room);
		rest      = rem_len_q - first_len;
		lim       = LIM_W'(bs) * LIM_W'(MAX_CHUNKS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (cmd.mul_start) begin
			mcnt_q <= MUL_CNT_W'(BS_W);
		end else if (mcnt_q != '0) begin
			mcnt_q <= mcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_len_q <= in_len;
			cur_off_q <= in_off;
			nchunk_q  <= '0;
		end
		if (cmd.cap_blk) begin
			blk_q  <= div_quot;
			disp_q <= div_rem;
		end
		if (cmd.cap_rnd) begin
			mcand_q <= div_quot;
			mod_q   <= div_rem[SC_W-1:0];
		end
		if (cmd.cap_si) begin
			si_q <= div_rem[SRV_W-1:0];
		end
		// round * block size, shift and add
		if (cmd.mul_start) begin
			acc_q    <= '0;
			mplier_q <= bs;
		end else if (mcnt_q != '0) begin
			acc_q    <= mplier_q[0] ? acc_q + mcand_q : acc_q;
			mcand_q  <= {mcand_q[OFF_W-2:0], 1'b0};
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.emit) begin
			srv_q     <= srv[SRV_W-1:0];
			clen_q    <= clen;
			loc_q     <= acc_q + OFF_W'(disp_q);
			oblk_q    <= blk_q;
			status_q  <= STAT_OK;
			last_q    <= new_rem == '0;
			wrap_q    <= new_off[OFF_W];
			rem_len_q <= new_rem;
			cur_off_q <= new_off[OFF_W-1:0];
			nchunk_q  <= nchunk_q + 1'b1;
			blk_q     <= blk_q + 1'b1;
			disp_q    <= '0;
			if (mod_inc == sc) begin
				mod_q <= '0;
				acc_q <= acc_q + OFF_W'(bs);
			end else begin
				mod_q <= mod_inc;
			end
		end else if (cmd.emit_empty || cmd.emit_reject) begin
			srv_q    <= '0;
			clen_q   <= '0;
			loc_q    <= '0;
			oblk_q   <= '0;
			status_q <= cmd.emit_empty ? STAT_EMPTY : STAT_REJECT;
			last_q   <= 1'b1;
			wrap_q   <= 1'b0;
		end
	end

	always_comb begin
		stat.len_zero = in_len == '0;
		stat.reject   = rest > OFF_W'(lim);
		stat.div_busy = div_busy;
		stat.mul_busy = mcnt_q != '0;
		stat.last     = last_q;
		stat.wrap     = wrap_q;
		stat.full     = nchunk_q == NCH_W'(MAX_CHUNKS);
	end

	assign m_tdata = {7'b0, oblk_q, loc_q, clen_q, srv_q};
	assign m_tuser = status_q;
	assign m_tlast = last_q;

endmodule

/* hw/rtl/rrss_ctrl.sv */
module rrss_ctrl
	import rrss_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   first_q, first_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = stat.len_zero ? ST_EMIT : ST_BLK_START;
					first_d = 1'b1;
				end
			end
			ST_BLK_START: state_d = ST_BLK_WAIT;
			ST_BLK_WAIT: begin
				if (!stat.div_busy) state_d = first_q ? ST_CHECK : ST_RND_START;
			end
			ST_CHECK:     state_d = stat.reject ? ST_EMIT : ST_RND_START;
			ST_RND_START: state_d = ST_RND_WAIT;
			ST_RND_WAIT: begin
				if (!stat.div_busy) state_d = first_q ? ST_SI_START : ST_MUL;
			end
			ST_SI_START: state_d = ST_SI_WAIT;
			ST_SI_WAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_MUL;
					first_d = 1'b0;
				end
			end
			ST_MUL: begin
				if (!stat.mul_busy) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_tready) begin
					if (stat.last || stat.full) begin
						state_d = ST_IDLE;
					end else if (stat.wrap) begin
						state_d = ST_BLK_START;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.emit_empty = stat.len_zero;
					cmd.load       = !stat.len_zero;
				end
			end
			ST_BLK_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_BLK;
			end
			ST_BLK_WAIT: cmd.cap_blk = !stat.div_busy;
			ST_CHECK:    cmd.emit_reject = stat.reject;
			ST_RND_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_RND;
			end
			ST_RND_WAIT: begin
				cmd.cap_rnd   = !stat.div_busy;
				cmd.mul_start = !stat.div_busy && !first_q;
			end
			ST_SI_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SI;
			end
			ST_SI_WAIT: begin
				cmd.cap_si    = !stat.div_busy;
				cmd.mul_start = !stat.div_busy;
			end
			ST_MUL: cmd.emit = !stat.mul_busy;
			ST_EMIT: begin
				m_tvalid = 1'b1;
				cmd.emit = m_tready && !stat.last && !stat.full && !stat.wrap;
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/rrss_chk.sv */
module rrss_chk
	import rrss_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled beat changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while result pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("not idle after last beat");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tlast)
		else $error("empty or reject beat without tlast");

endmodule

bind round_robin_stripe_splitter rrss_chk u_chk (.*);
